// ===== rtl/point_in_polygon_test_core_assert.svh =====
// Assertion macros shared by the point-in-polygon test core RTL.
`ifndef POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define PIP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pip_pkg.sv =====
// Shared types and codes of the point-in-polygon test core.
package pip_pkg;

  // Function codes carried in the input tuser bit
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Register index bit of the configuration address (byte address bit 2)
  localparam logic REG_EDGE_COUNT = 1'b0;

  // Tag that travels with each edge through the crossing pipeline
  typedef struct packed {
    logic vld;
    logic last;
  } pip_tag_t;

endpackage

// ===== rtl/point_in_polygon_test_core.sv =====
// Load item: accepted while idle, written to the edge table at that edge.
// Query item: the walk reads n table entries, one per cycle, n being edge_count
// saturated to MAX_EDGES; then the crossing pipeline drains and the parity is
// delivered; with n = 0 there is no walk. No item is taken until the result is
// registered for output. Loads follow back to back when idle. Reset clears
// control, edge_count and out_tvalid; table contents stay undefined until written.
module point_in_polygon_test_core #(
  parameter int MAX_EDGES  = 64,
  parameter int COORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [199:0] in_tdata,  // edge_index[5:0], edge_x1, edge_y1, edge_x2, edge_y2,
                                  // point_x, point_y (32 bits each), zero fill
  input  logic         in_tuser,  // func
  // Result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata, // inside_res, zero fill
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW   = $clog2(MAX_EDGES);
  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int EW   = 4 * COORD_BITS;
  localparam int CMPW = (CW > 7) ? CW : 7;

  localparam int IDX_LSB = 0;
  localparam int X1_LSB  = 6;
  localparam int Y1_LSB  = 38;
  localparam int X2_LSB  = 70;
  localparam int Y2_LSB  = 102;
  localparam int PX_LSB  = 134;
  localparam int PY_LSB  = 166;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_DONE} state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           addr_r, addr_nxt;
  logic [CW-1:0]           n_r, n_nxt, n_sat;
  logic [COORD_BITS-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic                    parity_r, parity_nxt, res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt, out_data_r, out_data_nxt;
  logic [6:0]              edge_count_r, edge_count_nxt;
  pip_pkg::pip_tag_t       rd_tag_r, rd_tag_nxt, xtag;

  logic                    in_accept, cfg_write, last_issue, flip, wr_en;
  logic [5:0]              in_idx;
  logic [CMPW-1:0]         cnt_ext;
  logic [EW-1:0]           wr_data, rd_data;

  // Handshakes
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == pip_pkg::REG_EDGE_COUNT) ? 32'(edge_count_r) : '0;

  // Saturate the edge count to the table size
  assign cnt_ext = CMPW'(edge_count_r);
  assign n_sat   = (cnt_ext > CMPW'(MAX_EDGES)) ? CW'(MAX_EDGES) : CW'(cnt_ext);

  // Edge loads go straight into the table
  assign in_idx  = in_tdata[IDX_LSB +: 6];
  assign wr_en   = in_accept && (in_tuser == pip_pkg::FUNC_LOAD)
                   && (32'(in_idx) < MAX_EDGES);
  assign wr_data = {in_tdata[Y2_LSB +: COORD_BITS], in_tdata[X2_LSB +: COORD_BITS],
                    in_tdata[Y1_LSB +: COORD_BITS], in_tdata[X1_LSB +: COORD_BITS]};

  assign last_issue = (state_r == S_WALK) && (CW'(addr_r) == (n_r - CW'(1)));

  pip_edge_mem #(
    .DEPTH (MAX_EDGES),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_idx)),
    .wr_data (wr_data),
    .rd_en   (state_r == S_WALK),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  pip_cross #(
    .CB (COORD_BITS)
  ) u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (rd_tag_r),
    .edge_in (rd_data),
    .px      (px_r),
    .py      (py_r),
    .tag_out (xtag),
    .flip    (flip)
  );

  // Sequence one query: walk the table, drain the pipeline, deliver the parity
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    n_nxt          = n_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    parity_nxt     = parity_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    edge_count_nxt = edge_count_r;

    rd_tag_nxt.vld  = (state_r == S_WALK);
    rd_tag_nxt.last = last_issue;

    if (cfg_write && (paddr[2] == pip_pkg::REG_EDGE_COUNT)) begin
      edge_count_nxt = pwdata[6:0];
    end
    if (xtag.vld && flip) begin
      parity_nxt = ~parity_r;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept && (in_tuser == pip_pkg::FUNC_QUERY)) begin
          px_nxt     = in_tdata[PX_LSB +: COORD_BITS];
          py_nxt     = in_tdata[PY_LSB +: COORD_BITS];
          n_nxt      = n_sat;
          addr_nxt   = '0;
          parity_nxt = 1'b0;
          if (n_sat == '0) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (last_issue) begin
          state_nxt = S_DRAIN;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_DRAIN: begin
        if (xtag.vld && xtag.last) begin
          res_nxt   = parity_r ^ flip;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, registered outputs and the query context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      edge_count_r <= '0;
      rd_tag_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      edge_count_r <= edge_count_nxt;
      rd_tag_r     <= rd_tag_nxt;
    end
    addr_r     <= addr_nxt;
    n_r        <= n_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    parity_r   <= parity_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_data_r};

`include "point_in_polygon_test_core_assert.svh"

  `PIP_ASSERT_SAME(a_out_from_done, $rose(out_valid_r), $past(state_r) == S_DONE, "result raised outside delivery")
  `PIP_ASSERT_SAME(a_last_in_drain, xtag.vld && xtag.last, state_r == S_DRAIN, "last edge outside drain")
  `PIP_ASSERT_SAME(a_tag_in_query, xtag.vld, state_r == S_WALK || state_r == S_DRAIN, "edge result while not querying")
  `PIP_ASSERT_SAME(a_addr_in_range, state_r == S_WALK, CW'(addr_r) < n_r, "walk address beyond edge count")

endmodule

// ===== rtl/pip_edge_mem.sv =====
// Edge table: synchronous memory with one write port and one registered read port.
module pip_edge_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one edge
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one edge, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/pip_cross.sv =====
// Crossing test pipeline: orient edge, span check, cross-multiply, compare.
module pip_cross #(
  parameter int CB = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pip_pkg::pip_tag_t   tag_in,
  input  logic [4*CB-1:0]     edge_in,   // x1, y1, x2, y2 from the lowest bits up
  input  logic [CB-1:0]       px,
  input  logic [CB-1:0]       py,
  output pip_pkg::pip_tag_t   tag_out,
  output logic                flip
);

  logic signed [CB-1:0]   x1, y1, x2, y2, xa, ya, xb, yb, px_s, py_s;
  logic                   span;
  logic signed [CB:0]     dxp, dye, dxe, dyp;

  pip_pkg::pip_tag_t      tag_a_r, tag_b_r, tag_c_r;
  logic                   span_a_r, span_b_r, flip_r;
  logic signed [CB:0]     dxp_r, dye_r, dxe_r, dyp_r;
  logic signed [2*CB+1:0] p1_r, p2_r;

  // Orient the edge so that endpoint a is the lower one
  always_comb begin
    x1   = $signed(edge_in[0*CB +: CB]);
    y1   = $signed(edge_in[1*CB +: CB]);
    x2   = $signed(edge_in[2*CB +: CB]);
    y2   = $signed(edge_in[3*CB +: CB]);
    px_s = $signed(px);
    py_s = $signed(py);
    if (y1 <= y2) begin
      xa = x1; ya = y1; xb = x2; yb = y2;
    end else begin
      xa = x2; ya = y2; xb = x1; yb = y1;
    end
    span = (ya <= py_s) && (py_s < yb);
    dxp  = $signed({px_s[CB-1], px_s}) - $signed({xa[CB-1], xa});
    dye  = $signed({yb[CB-1], yb})     - $signed({ya[CB-1], ya});
    dxe  = $signed({xb[CB-1], xb})     - $signed({xa[CB-1], xa});
    dyp  = $signed({py_s[CB-1], py_s}) - $signed({ya[CB-1], ya});
  end

  // Advance tags through the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      tag_c_r <= '0;
    end else begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
      tag_c_r <= tag_b_r;
    end
  end

  // Hold differences, products and the crossing flag
  always_ff @(posedge clk) begin
    span_a_r <= span;
    dxp_r    <= dxp;
    dye_r    <= dye;
    dxe_r    <= dxe;
    dyp_r    <= dyp;
    span_b_r <= span_a_r;
    p1_r     <= dxp_r * dye_r;
    p2_r     <= dxe_r * dyp_r;
    flip_r   <= span_b_r && (p1_r < p2_r);
  end

  assign tag_out = tag_c_r;
  assign flip    = flip_r;

endmodule
